// ===== rtl/ptmr_pkg.sv =====
package ptmr_pkg;

  typedef enum logic [1:0] {
    DEC_TRIVIAL = 2'd0,
    DEC_TRIAL   = 2'd1,
    DEC_MR      = 2'd2
  } decided_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  localparam int unsigned OddPrimeTotal = 167;

  localparam logic [9:0] ODD_PRIMES [0:166] = '{
    10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29, 10'd31,
    10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71, 10'd73,
    10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
    10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167,
    10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
    10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269,
    10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317,
    10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367, 10'd373, 10'd379,
    10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431, 10'd433,
    10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479, 10'd487,
    10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557,
    10'd563, 10'd569, 10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607,
    10'd613, 10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
    10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719, 10'd727,
    10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769, 10'd773, 10'd787,
    10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827, 10'd829, 10'd839, 10'd853,
    10'd857, 10'd859, 10'd863, 10'd877, 10'd881, 10'd883, 10'd887, 10'd907, 10'd911,
    10'd919, 10'd929, 10'd937, 10'd941, 10'd947, 10'd953, 10'd967, 10'd971, 10'd977,
    10'd983, 10'd991, 10'd997
  };

  localparam logic [4:0] MR_BASES [0:10] = '{
    5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29, 5'd31
  };

  function automatic logic [9:0] odd_prime(logic [7:0] idx);
    logic [9:0] p;
    p = 10'd0;
    if (idx < 8'(OddPrimeTotal)) begin
      p = ODD_PRIMES[idx];
    end
    return p;
  endfunction

  function automatic logic [4:0] mr_base(logic [3:0] idx);
    logic [4:0] b;
    b = 5'd0;
    if (idx < 4'd11) begin
      b = MR_BASES[idx];
    end
    return b;
  endfunction

endpackage

// ===== rtl/ptmr_modmul.sv =====
module ptmr_modmul #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        a_i,
  input  logic [W-1:0]        b_i,
  input  logic [W-1:0]        m_i,
  output ptmr_pkg::mm_stat_t  stat_o,
  output logic [W-1:0]        r_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] a_q, b_q, m_q, acc_q;
  logic [CW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [W:0] t, t2, u, u2, m_ext;

  always_comb begin
    m_ext = {1'b0, m_q};
    t = {acc_q, 1'b0};
    t2 = (t >= m_ext) ? (t - m_ext) : t;
    u = t2 + (a_q[W-1] ? {1'b0, b_q} : '0);
    u2 = (u >= m_ext) ? (u - m_ext) : u;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q <= {a_q[W-2:0], 1'b0};
      acc_q <= u2[W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign r_o = acc_q;

endmodule

// ===== rtl/ptmr_ctrl.sv =====
module ptmr_ctrl #(
  parameter int unsigned W   = 32,
  parameter int unsigned SPC = 167,
  parameter int unsigned KW  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [W-1:0]        n_i,
  input  logic [KW-1:0]       count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                is_prime_o,
  output ptmr_pkg::decided_e  decided_o,
  output logic                mm_start_o,
  output logic [W-1:0]        mm_a_o,
  output logic [W-1:0]        mm_b_o,
  output logic [W-1:0]        mm_m_o,
  input  ptmr_pkg::mm_stat_t  mm_stat_i,
  input  logic [W-1:0]        mm_r_i
);

  localparam int unsigned IW = $clog2(SPC + 1);
  localparam int unsigned SW = $clog2(W);

  typedef enum logic [3:0] {
    S_IDLE, S_TD, S_SHIFT, S_BASE, S_POW, S_SQ, S_CHECK, S_LOOP, S_WAIT, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_TD, OP_BMOD, OP_ACC, OP_SQ, OP_LOOP
  } op_e;

  state_e state_q;
  op_e op_q;
  logic [W-1:0] n_q, d_q, e_q, b_q, acc_q, x_q;
  logic [W-1:0] mm_a_q, mm_b_q, mm_m_q, nm1, p_ext;
  logic [SW-1:0] s_q, j_q;
  logic [IW-1:0] i_q;
  logic [KW-1:0] k_q, count_q;
  logic mm_start_q, out_valid_q, out_prime_q, fin_prime_q;
  ptmr_pkg::decided_e out_dec_q, fin_dec_q;

  assign nm1 = n_q - W'(1);
  assign p_ext = W'(ptmr_pkg::odd_prime(8'(i_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= OP_TD;
      mm_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_prime_q <= 1'b0;
      out_dec_q <= ptmr_pkg::DEC_TRIVIAL;
      fin_prime_q <= 1'b0;
      fin_dec_q <= ptmr_pkg::DEC_TRIVIAL;
      n_q <= '0; d_q <= '0; e_q <= '0; b_q <= '0; acc_q <= '0; x_q <= '0;
      mm_a_q <= '0; mm_b_q <= '0; mm_m_q <= '0;
      s_q <= '0; j_q <= '0; i_q <= '0; k_q <= '0; count_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            n_q <= n_i;
            count_q <= count_i;
            if (n_i < W'(3) || !n_i[0]) begin
              fin_prime_q <= 1'b0;
              fin_dec_q <= ptmr_pkg::DEC_TRIVIAL;
              state_q <= S_DONE;
            end else begin
              i_q <= '0;
              state_q <= S_TD;
            end
          end
        end
        S_TD: begin
          if (n_q == p_ext) begin
            fin_prime_q <= 1'b1;
            fin_dec_q <= ptmr_pkg::DEC_TRIAL;
            state_q <= S_DONE;
          end else begin
            mm_a_q <= n_q;
            mm_b_q <= W'(1);
            mm_m_q <= p_ext;
            mm_start_q <= 1'b1;
            op_q <= OP_TD;
            state_q <= S_WAIT;
          end
        end
        S_SHIFT: begin
          if (!d_q[0] && d_q != '0) begin
            d_q <= d_q >> 1;
            s_q <= s_q + SW'(1);
          end else begin
            k_q <= '0;
            state_q <= S_BASE;
          end
        end
        S_BASE: begin
          if (k_q == count_q) begin
            fin_prime_q <= 1'b1;
            fin_dec_q <= ptmr_pkg::DEC_MR;
            state_q <= S_DONE;
          end else begin
            mm_a_q <= W'(ptmr_pkg::mr_base(4'(k_q)));
            mm_b_q <= W'(1);
            mm_m_q <= n_q;
            mm_start_q <= 1'b1;
            op_q <= OP_BMOD;
            state_q <= S_WAIT;
          end
        end
        S_POW: begin
          if (e_q == '0) begin
            state_q <= S_CHECK;
          end else if (e_q[0]) begin
            mm_a_q <= acc_q;
            mm_b_q <= b_q;
            mm_m_q <= n_q;
            mm_start_q <= 1'b1;
            op_q <= OP_ACC;
            state_q <= S_WAIT;
          end else begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          mm_a_q <= b_q;
          mm_b_q <= b_q;
          mm_m_q <= n_q;
          mm_start_q <= 1'b1;
          op_q <= OP_SQ;
          state_q <= S_WAIT;
        end
        S_CHECK: begin
          x_q <= acc_q;
          if (acc_q == W'(1) || acc_q == nm1) begin
            k_q <= k_q + KW'(1);
            state_q <= S_BASE;
          end else begin
            j_q <= SW'(1);
            state_q <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (j_q >= s_q) begin
            fin_prime_q <= 1'b0;
            fin_dec_q <= ptmr_pkg::DEC_MR;
            state_q <= S_DONE;
          end else begin
            mm_a_q <= x_q;
            mm_b_q <= x_q;
            mm_m_q <= n_q;
            mm_start_q <= 1'b1;
            op_q <= OP_LOOP;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          mm_start_q <= 1'b0;
          if (mm_stat_i.done) begin
            case (op_q)
              OP_TD: begin
                if (mm_r_i == '0) begin
                  fin_prime_q <= 1'b0;
                  fin_dec_q <= ptmr_pkg::DEC_TRIAL;
                  state_q <= S_DONE;
                end else if (i_q == IW'(SPC - 1)) begin
                  d_q <= nm1;
                  s_q <= '0;
                  state_q <= S_SHIFT;
                end else begin
                  i_q <= i_q + IW'(1);
                  state_q <= S_TD;
                end
              end
              OP_BMOD: begin
                if (mm_r_i == '0) begin
                  k_q <= k_q + KW'(1);
                  state_q <= S_BASE;
                end else begin
                  b_q <= mm_r_i;
                  acc_q <= W'(1);
                  e_q <= d_q;
                  state_q <= S_POW;
                end
              end
              OP_ACC: begin
                acc_q <= mm_r_i;
                state_q <= S_SQ;
              end
              OP_SQ: begin
                b_q <= mm_r_i;
                e_q <= e_q >> 1;
                state_q <= S_POW;
              end
              OP_LOOP: begin
                x_q <= mm_r_i;
                if (mm_r_i == nm1) begin
                  k_q <= k_q + KW'(1);
                  state_q <= S_BASE;
                end else if (mm_r_i == W'(1)) begin
                  fin_prime_q <= 1'b0;
                  fin_dec_q <= ptmr_pkg::DEC_MR;
                  state_q <= S_DONE;
                end else begin
                  j_q <= j_q + SW'(1);
                  state_q <= S_LOOP;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_prime_q <= fin_prime_q;
            out_dec_q <= fin_dec_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o = out_prime_q;
  assign decided_o = out_dec_q;
  assign mm_start_o = mm_start_q;
  assign mm_a_o = mm_a_q;
  assign mm_b_o = mm_b_q;
  assign mm_m_o = mm_m_q;

endmodule

// ===== rtl/primality_test_trial_miller_rabin_core.sv =====
// primality test core: trial division by the odd primes 3..997, then a
// deterministic miller-rabin test with the first 'rounds' primes as bases.
// input stream: s_axis carries one candidate per item in tdata[31:0].
// output stream: m_axis returns one item per candidate, tdata[0] is_prime,
// tdata[2:1] decided_by (0 below three or even, 1 trial division, 2 m-r).
// config: cfg_we_i writes cfg_data_i into the rounds register (reset 11);
// zero acts as one round, values above MAX_ROUNDS saturate.
// one item is worked on at a time; tready is high only while idle.
// candidates below three or even need no multiply; each modular multiply
// runs on the shared bit-serial unit. trial division costs one multiply
// per prime (up to SMALL_PRIME_COUNT); miller-rabin costs per base about
// 2 * NUMBER_BITS multiplies plus up to NUMBER_BITS - 1 squarings.
// the result sits in an output register; while the receiver stalls the
// next candidate is accepted and processed, finishing waits on the register.
// reset clears the controller and the output valid and sets rounds to 11.
module primality_test_trial_miller_rabin_core #(
  parameter int unsigned NUMBER_BITS       = 32,
  parameter int unsigned SMALL_PRIME_COUNT = 167,
  parameter int unsigned MAX_ROUNDS        = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // candidate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // is_prime, decided_by, zero pad
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned W  = NUMBER_BITS;
  localparam int unsigned KW = $clog2(MAX_ROUNDS + 1);

  logic [3:0] rounds_q;
  logic [KW-1:0] count;
  logic mm_start, is_prime;
  logic [W-1:0] mm_a, mm_b, mm_m, mm_r;
  ptmr_pkg::mm_stat_t mm_stat;
  ptmr_pkg::decided_e decided;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= 4'd11;
    end else if (cfg_we_i) begin
      rounds_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (rounds_q == 4'd0) begin
      count = KW'(1);
    end else if (rounds_q > 4'(MAX_ROUNDS)) begin
      count = KW'(MAX_ROUNDS);
    end else begin
      count = KW'(rounds_q);
    end
  end

  ptmr_ctrl #(.W(W), .SPC(SMALL_PRIME_COUNT), .KW(KW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .n_i         (s_axis_tdata[W-1:0]),
    .count_i     (count),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .is_prime_o  (is_prime),
    .decided_o   (decided),
    .mm_start_o  (mm_start),
    .mm_a_o      (mm_a),
    .mm_b_o      (mm_b),
    .mm_m_o      (mm_m),
    .mm_stat_i   (mm_stat),
    .mm_r_i      (mm_r)
  );

  ptmr_modmul #(.W(W)) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (mm_m),
    .stat_o  (mm_stat),
    .r_o     (mm_r)
  );

  assign m_axis_tdata = {5'd0, decided, is_prime};

endmodule

// ===== rtl/ptmr_checker.sv =====
module ptmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        cfg_we_i,
  input logic [3:0]  cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accepting an item");

  a_trivial_not_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:1] == 2'd0 |-> !m_axis_tdata[0])
    else $error("trivial decision marked prime");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:1] != 2'd3 && m_axis_tdata[7:3] == 5'd0)
    else $error("bad decided_by code or padding");

endmodule

bind primality_test_trial_miller_rabin_core ptmr_checker u_ptmr_checker (.*);
